@@ design/rtd_pkg.sv @@
package rtd_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // field widths
    localparam int IDX_W    = 9;
    localparam int RES_W    = 20;
    localparam int RAW_W    = 16;
    localparam int CODE_W   = RAW_W - 1;
    localparam int GAIN_W   = 24;
    localparam int LC_W     = 9;
    localparam int TOP_W    = 9;
    localparam int DEG_W    = 11;
    localparam int FRAC_W   = 7;

    // scaled code = code * 1000, fits 25 bits
    localparam int SCALED_W = CODE_W + 10;
    // milliohm + 5, fits one bit more than the product high half
    localparam int MILLI_W  = SCALED_W + 1;

    localparam logic [RES_W-1:0]  RES_MAX  = '1;
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(99);

    // request commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = CFG_IDX_W'(2);

    localparam logic signed [LC_W-1:0] LOWEST_RST = -9'sd200;
    localparam logic [TOP_W-1:0]       TOP_RST    = TOP_W'(510);

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   table_index;
        logic [RES_W-1:0]   entry_centiohm;
        logic [RAW_W-1:0]   raw_reading;
    } t_req;

    typedef struct packed {
        logic signed [DEG_W-1:0] whole_degrees;
        logic [FRAC_W-1:0]       hundredths;
        logic [RES_W-1:0]        resistance_centiohm;
        logic                    out_of_table;
    } t_res;

endpackage

@@ design/rtd_code_to_temperature.sv @@
// RTD code to temperature converter.
//
// Request channel (i_req_valid / o_req_ready / i_req_data): each request is
// either a table load (cmd = load), which writes one centiohm entry of the
// ascending one-degree-step resistance table, or a conversion (cmd =
// convert) of a raw 16-bit converter word. Loads give no result; each
// conversion gives exactly one result on the result channel
// (o_res_valid / i_res_ready / o_res_data): signed whole degrees,
// hundredths, the scaled resistance and an out-of-table flag.
//
// A load is written when accepted and leaves the block idle. A conversion
// runs from acceptance to o_res_valid through a 24-step bit-serial gain
// multiply, a 26-step bit-serial divide by ten, up to nine probes on the
// single table read port, two reads (the entry and one neighbour) and a
// 7-step fraction divide. One request is worked on at a time; the next is
// taken the cycle after the previous result enters the output register.
//
// A finished result sits in the output register; if the receiver stalls,
// the block still takes one further conversion and holds its result until
// the register frees up. Reset (i_rst_n low, synchronous) empties the
// output register, returns to idle and sets gain 0, lowest -200 and search
// top 510. The table is not cleared: entries must be loaded before use.
// Configuration (i_cfg_*), always ready, must be written only while idle.
module rtd_code_to_temperature
    import rtd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req_data,

    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_res                  o_res_data,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // widths for range checks against the table depth
    localparam int IW_MAX = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int CMP_W  = IW_MAX + 2;
    // degree arithmetic width, truncated to the field at the end
    localparam int WW     = (ADDR_W + 2 > DEG_W) ? ADDR_W + 2 : DEG_W;

    localparam logic [ADDR_W-1:0] IDX_MIN = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] IDX_MAX = ADDR_W'(TABLE_DEPTH - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ROUND,
        S_DIV10,
        S_SAT,
        S_SRCH,
        S_PROBE,
        S_CLAMP,
        S_UPPER,
        S_OTHER,
        S_PREP,
        S_SCALE,
        S_DIVF,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [4:0]             r_cnt;

    // configuration
    logic [GAIN_W-1:0]      r_gain;
    logic signed [LC_W-1:0] r_lowest;
    logic [TOP_W-1:0]       r_top;

    // multiply: product = {r_phi, r_plo}
    logic [SCALED_W-1:0]    r_m;
    logic [GAIN_W-1:0]      r_g;
    logic [SCALED_W-1:0]    r_phi;
    logic [GAIN_W-1:0]      r_plo;

    // divide by ten
    logic [MILLI_W-1:0]     r_num;
    logic [3:0]             r_rem10;

    logic [RES_W-1:0]       r_res;
    logic                   r_flag;

    // search
    logic [ADDR_W-1:0]      r_slo;
    logic [ADDR_W-1:0]      r_shi;
    logic [ADDR_W-1:0]      r_mid;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_up;

    // interpolation
    logic [RES_W-1:0]       r_base;
    logic [RES_W-1:0]       r_next;
    logic [RES_W-1:0]       r_n;
    logic [RES_W-1:0]       r_d;
    logic [RES_W-1:0]       r_rem;
    logic [FRAC_W-1:0]      r_nlo;
    logic [FRAC_W-1:0]      r_frac;

    logic                   r_out_valid;
    t_res                   r_out;

    // table memory
    logic [RES_W-1:0]       r_table [TABLE_DEPTH];
    logic [RES_W-1:0]       r_rd_data;
    logic [ADDR_W-1:0]      rd_addr;

    logic                   req_fire;
    logic                   load_ok;
    logic                   mem_we;
    logic                   out_free;

    logic [CODE_W-1:0]      code;
    logic [SCALED_W-1:0]    code_scaled;
    logic [SCALED_W:0]      mul_sum;
    logic [MILLI_W-1:0]     milli_p5;
    logic [4:0]             d10_t;
    logic                   d10_ge;
    logic [CMP_W-1:0]       top_ext;
    logic [ADDR_W-1:0]      top_lim;
    logic [ADDR_W:0]        top_half;
    logic [ADDR_W-1:0]      n_slo;
    logic [ADDR_W-1:0]      n_shi;
    logic [ADDR_W:0]        mid_sum;
    logic [ADDR_W-1:0]      n_mid;
    logic [ADDR_W-1:0]      idx_c;
    logic                   idx_clamped;
    logic [RES_W+6:0]       n_x100;
    logic [RES_W:0]         df_t;
    logic [RES_W:0]         df_diff;
    logic                   df_ge;
    logic [WW-1:0]          whole_w;

    assign req_fire    = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out;
    assign out_free    = !r_out_valid || i_res_ready;

    // loads beyond the table are dropped
    assign load_ok = CMP_W'(i_req_data.table_index) < CMP_W'(TABLE_DEPTH);
    assign mem_we  = req_fire && (i_req_data.cmd == CMD_LOAD) && load_ok;

    // code * 1000 = (c << 10) - (c << 5) + (c << 3)
    assign code        = i_req_data.raw_reading[RAW_W-1:1];
    assign code_scaled = (SCALED_W'(code) << 10) - (SCALED_W'(code) << 5)
                       + (SCALED_W'(code) << 3);

    // one gain bit per cycle, LSB first
    assign mul_sum  = {1'b0, r_phi} + (r_g[0] ? {1'b0, r_m} : '0);

    // round to milliohms (bit 23 of product) and add half a centiohm
    assign milli_p5 = MILLI_W'(r_phi) + MILLI_W'(r_plo[GAIN_W-1]) + MILLI_W'(5);

    // restoring divide by ten, one quotient bit per cycle
    assign d10_t  = {r_rem10, r_num[MILLI_W-1]};
    assign d10_ge = (d10_t >= 5'd10);

    assign top_ext  = CMP_W'(r_top);
    assign top_lim  = (top_ext > CMP_W'(TABLE_DEPTH - 1)) ? ADDR_W'(TABLE_DEPTH - 1)
                                                          : ADDR_W'(r_top);
    assign top_half = {1'b0, top_lim} >> 1;

    // probe update
    always_comb begin
        n_slo = r_slo;
        n_shi = r_shi;
        if (r_rd_data < r_res) begin
            n_slo = r_mid + ADDR_W'(1);
        end else begin
            n_shi = r_mid;
        end
        mid_sum = {1'b0, n_slo} + {1'b0, n_shi};
        n_mid   = mid_sum[ADDR_W:1];
    end

    // keep the index one entry away from both table ends
    always_comb begin
        idx_c       = r_mid;
        idx_clamped = 1'b0;
        if (r_mid < IDX_MIN) begin
            idx_c       = IDX_MIN;
            idx_clamped = 1'b1;
        end else if (r_mid > IDX_MAX) begin
            idx_c       = IDX_MAX;
            idx_clamped = 1'b1;
        end
    end

    // table read address
    always_comb begin
        unique case (r_state)
            S_CLAMP: rd_addr = idx_c;
            S_UPPER: rd_addr = (r_res < r_rd_data) ? r_idx - ADDR_W'(1)
                                                   : r_idx + ADDR_W'(1);
            default: rd_addr = r_mid;
        endcase
    end

    // n * 100 = (n << 6) + (n << 5) + (n << 2)
    assign n_x100 = ((RES_W+7)'(r_n) << 6) + ((RES_W+7)'(r_n) << 5)
                  + ((RES_W+7)'(r_n) << 2);

    // fraction divide, one quotient bit per cycle
    assign df_t    = {r_rem, r_nlo[FRAC_W-1]};
    assign df_ge   = (df_t >= {1'b0, r_d});
    assign df_diff = df_t - {1'b0, r_d};

    assign whole_w = WW'(r_idx) + WW'(r_lowest) + WW'(r_up) - WW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[ADDR_W'(i_req_data.table_index)] <= i_req_data.entry_centiohm;
        end
        r_rd_data <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= '0;
            r_lowest <= LOWEST_RST;
            r_top    <= TOP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_LOWEST: r_lowest <= i_cfg_data[LC_W-1:0];
                CFG_TOP:    r_top    <= i_cfg_data[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_fire && (i_req_data.cmd == CMD_CONVERT)) begin
                        r_m     <= code_scaled;
                        r_g     <= r_gain;
                        r_phi   <= '0;
                        r_plo   <= '0;
                        r_cnt   <= 5'(GAIN_W - 1);
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    r_phi <= mul_sum[SCALED_W:1];
                    r_plo <= {mul_sum[0], r_plo[GAIN_W-1:1]};
                    r_g   <= r_g >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_ROUND;
                    end
                end

                S_ROUND: begin
                    r_num   <= milli_p5;
                    r_rem10 <= '0;
                    r_cnt   <= 5'(MILLI_W - 1);
                    r_state <= S_DIV10;
                end

                S_DIV10: begin
                    r_rem10 <= d10_ge ? 4'(d10_t - 5'd10) : d10_t[3:0];
                    r_num   <= {r_num[MILLI_W-2:0], d10_ge};
                    r_cnt   <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_SAT;
                    end
                end

                S_SAT: begin
                    // saturate the centiohm value
                    if (|r_num[MILLI_W-1:RES_W]) begin
                        r_res  <= RES_MAX;
                        r_flag <= 1'b1;
                    end else begin
                        r_res  <= r_num[RES_W-1:0];
                        r_flag <= 1'b0;
                    end
                    r_slo   <= '0;
                    r_shi   <= top_lim;
                    r_mid   <= top_half[ADDR_W-1:0];
                    r_state <= S_SRCH;
                end

                S_SRCH: begin
                    r_state <= (r_slo < r_shi) ? S_PROBE : S_CLAMP;
                end

                S_PROBE: begin
                    if (r_rd_data == r_res) begin
                        r_state <= S_CLAMP;
                    end else begin
                        r_slo   <= n_slo;
                        r_shi   <= n_shi;
                        r_mid   <= n_mid;
                        r_state <= S_SRCH;
                    end
                end

                S_CLAMP: begin
                    r_idx   <= idx_c;
                    r_flag  <= r_flag || idx_clamped;
                    r_state <= S_UPPER;
                end

                S_UPPER: begin
                    if (r_res == r_rd_data) begin
                        r_up    <= 1'b1;
                        r_frac  <= '0;
                        r_state <= S_FINISH;
                    end else if (r_res < r_rd_data) begin
                        // between lower neighbour and this entry
                        r_up    <= 1'b0;
                        r_next  <= r_rd_data;
                        r_state <= S_OTHER;
                    end else begin
                        // between this entry and upper neighbour
                        r_up    <= 1'b1;
                        r_base  <= r_rd_data;
                        r_state <= S_OTHER;
                    end
                end

                S_OTHER: begin
                    if (r_up) begin
                        r_next <= r_rd_data;
                    end else begin
                        r_base <= r_rd_data;
                    end
                    r_state <= S_PREP;
                end

                S_PREP: begin
                    if ((r_next <= r_base) || (r_res < r_base)) begin
                        r_frac  <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_n     <= r_res - r_base;
                        r_d     <= r_next - r_base;
                        r_state <= S_SCALE;
                    end
                end

                S_SCALE: begin
                    // quotient reaches 100 exactly when n >= d
                    if (r_n >= r_d) begin
                        r_frac  <= FRAC_MAX;
                        r_state <= S_FINISH;
                    end else begin
                        r_rem   <= n_x100[RES_W+6:FRAC_W];
                        r_nlo   <= n_x100[FRAC_W-1:0];
                        r_cnt   <= 5'(FRAC_W - 1);
                        r_state <= S_DIVF;
                    end
                end

                S_DIVF: begin
                    r_rem  <= df_ge ? df_diff[RES_W-1:0] : df_t[RES_W-1:0];
                    r_nlo  <= r_nlo << 1;
                    r_frac <= {r_frac[FRAC_W-2:0], df_ge};
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (out_free) begin
                        r_out.whole_degrees       <= whole_w[DEG_W-1:0];
                        r_out.hundredths          <= r_frac;
                        r_out.resistance_centiohm <= r_res;
                        r_out.out_of_table        <= r_flag;
                        r_out_valid               <= 1'b1;
                        r_state                   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // search window never inverts
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_PROBE) |-> (r_slo <= r_shi))
        else $error("search window inverted");

    // partial remainder stays below the divisor
    a_frac_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVF) |-> (r_rem < r_d))
        else $error("fraction divide remainder out of range");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res_data.hundredths <= FRAC_MAX))
        else $error("hundredths above 99");

    // a load never starts a conversion
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && (i_req_data.cmd == CMD_LOAD)) |=> (r_state == S_IDLE))
        else $error("load left idle state");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import rtd_pkg::*;

    // Run limits. A slow but correct run, with the longest conversions,
    // sender gaps and receiver stalls, stays well below LIMIT_CYCLES.
    localparam int LIMIT_CYCLES  = 1_000_000;
    // Quiet time before a register write or the end check. It covers the
    // longest conversion, since a load gives no result to wait for.
    localparam int SETTLE_CYCLES = 100;
    localparam int CODE_MAX      = (1 << CODE_W) - 1;
    // 0.5 ohm per code: resistance = code * 50 centiohm exactly
    localparam int GAIN_HALF_OHM = 1 << 23;
    localparam int GAIN_PT1000   = 2048000;

    typedef enum {
        SHAPE_PT1000,
        SHAPE_PLATEAU,
        SHAPE_NOISY
    } table_shape_e;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req_data  = '0;
    logic                  o_res_valid;
    logic                  i_res_ready = 1'b0;
    t_res                  o_res_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_GAIN;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    rtd_code_to_temperature DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_data  (i_req_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_data  (o_res_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the resistance table and of the
    // three registers, updated when the DUT accepts a request or a write.
    // ------------------------------------------------------------------
    logic [RES_W-1:0]        res_model [TABLE_DEPTH];
    logic [GAIN_W-1:0]       gain_cfg   = '0;
    logic signed [LC_W-1:0]  lowest_cfg = LOWEST_RST;
    logic [TOP_W-1:0]        top_cfg    = TOP_RST;

    // expected temperatures, oldest first
    t_res expected_temps [$];
    int   n_expected  = 0;
    int   n_fail      = 0;
    int   cycle_count = 0;

    // one-slot mailbox between the test tasks and the request driver
    t_req req_slot    = '0;
    bit   req_pending = 1'b0;

    // idle pressure, in percent, changed per phase
    int req_gap_pct   = 25;
    int res_stall_pct = 25;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // hundredths of the way from base to nxt; 0 on a flat or falling step
    // or when r sits below base, capped at 99 when r overshoots nxt
    function automatic int unsigned step_fraction(int unsigned r, int unsigned base,
                                                  int unsigned nxt);
        longint unsigned q;
        if (nxt <= base || r < base) begin
            return 0;
        end
        q = r - base;
        q = (q * 100) / (nxt - base);
        return (q > 99) ? 99 : int'(q);
    endfunction

    function automatic t_res predict_temperature(t_req r);
        t_res            o;
        longint unsigned milli;
        longint unsigned centi;
        int unsigned     res, top, lo, hi, mid, idx, lower, upper, frac;
        int              whole;
        bit              flag;

        // drop the fault bit, scale to milliohm, round, then to centiohm
        milli = r.raw_reading[RAW_W-1:1];
        milli = milli * gain_cfg;
        milli = milli * 64'd1000;
        milli = (milli + 64'd8388608) >> 24;
        centi = (milli + 5) / 10;
        flag  = 1'b0;
        if (centi > RES_MAX) begin
            centi = RES_MAX;
            flag  = 1'b1;
        end
        res = centi[31:0];

        // binary search; stops early on an exact hit
        top = top_cfg;
        if (top > TABLE_DEPTH - 1) begin
            top = TABLE_DEPTH - 1;
        end
        lo  = 0;
        hi  = top;
        mid = (lo + hi) / 2;
        while (lo < hi && res_model[mid] != res) begin
            if (res_model[mid] < res) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
            mid = (lo + hi) / 2;
        end

        // keep both neighbours inside the table
        idx = mid;
        if (idx < 1) begin
            idx  = 1;
            flag = 1'b1;
        end else if (idx > TABLE_DEPTH - 2) begin
            idx  = TABLE_DEPTH - 2;
            flag = 1'b1;
        end

        whole = int'(idx) - 1 + int'(lowest_cfg);
        lower = res_model[idx - 1];
        upper = res_model[idx];
        if (res < upper) begin
            frac = step_fraction(res, lower, upper);
        end else if (res > upper) begin
            whole++;
            frac = step_fraction(res, upper, res_model[idx + 1]);
        end else begin
            whole++;
            frac = 0;
        end

        o.whole_degrees       = whole[DEG_W-1:0];
        o.hundredths          = frac[FRAC_W-1:0];
        o.resistance_centiohm = res[RES_W-1:0];
        o.out_of_table        = flag;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, a few long ones; pct is the chance to idle at all
    function automatic int idle_length(int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Drives on the falling edge, sees the handshake on
    // the rising edge. Valid only drops when no request is waiting or a
    // gap is drawn, so back-to-back requests keep valid high.
    // ------------------------------------------------------------------
    initial begin : request_driver
        int gap;
        forever begin
            @(negedge i_clk);
            if (!req_pending) begin
                i_req_valid <= 1'b0;
            end else begin
                gap = idle_length(req_gap_pct);
                if (gap > 0) begin
                    i_req_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                i_req_valid <= 1'b1;
                i_req_data  <= req_slot;
                @(posedge i_clk);
                while (!o_req_ready) @(posedge i_clk);
                // accepted: loads update the table copy, conversions
                // queue their expected temperature
                if (req_slot.cmd == CMD_LOAD) begin
                    res_model[req_slot.table_index] = req_slot.entry_centiohm;
                end else begin
                    expected_temps.push_back(predict_temperature(req_slot));
                    n_expected++;
                end
                req_pending = 1'b0;
            end
        end
    end

    // receiver: random stalls of the result channel
    initial begin : result_ready_driver
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall == 0) begin
                stall = idle_length(res_stall_pct);
            end
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                stall--;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    initial begin : result_checker
        t_res want;
        t_res got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready) begin
                got = o_res_data;
                if (n_expected == 0) begin
                    $error("unexpected result: whole_degrees %0d hundredths %0d",
                           got.whole_degrees, got.hundredths);
                    n_fail++;
                end else begin
                    want = expected_temps.pop_front();
                    n_expected--;
                    if (got.whole_degrees !== want.whole_degrees) begin
                        $error("whole_degrees: expected %0d, got %0d",
                               want.whole_degrees, got.whole_degrees);
                        n_fail++;
                    end
                    if (got.hundredths !== want.hundredths) begin
                        $error("hundredths: expected %0d, got %0d",
                               want.hundredths, got.hundredths);
                        n_fail++;
                    end
                    if (got.resistance_centiohm !== want.resistance_centiohm) begin
                        $error("resistance_centiohm: expected %0d, got %0d",
                               want.resistance_centiohm, got.resistance_centiohm);
                        n_fail++;
                    end
                    if (got.out_of_table !== want.out_of_table) begin
                        $error("out_of_table: expected %0d, got %0d",
                               want.out_of_table, got.out_of_table);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------
    task automatic send_request(t_req r);
        req_slot    = r;
        req_pending = 1'b1;
        wait (!req_pending);
    endtask

    // unused fields carry random junk
    task automatic load_entry(int unsigned idx, logic [RES_W-1:0] centiohm);
        logic [63:0] junk;
        t_req        r;
        junk             = {$urandom, $urandom};
        r                = junk[$bits(t_req)-1:0];
        r.cmd            = CMD_LOAD;
        r.table_index    = idx[IDX_W-1:0];
        r.entry_centiohm = centiohm;
        send_request(r);
    endtask

    task automatic convert(logic [CODE_W-1:0] code, bit fault);
        logic [63:0] junk;
        t_req        r;
        junk          = {$urandom, $urandom};
        r             = junk[$bits(t_req)-1:0];
        r.cmd         = CMD_CONVERT;
        r.raw_reading = {code, fault};
        send_request(r);
    endtask

    task automatic wait_drained();
        wait (n_expected == 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_GAIN:   gain_cfg   = value[GAIN_W-1:0];
            CFG_LOWEST: lowest_cfg = value[LC_W-1:0];
            CFG_TOP:    top_cfg    = value[TOP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // waits for the block to go idle, then writes all three registers
    task automatic set_config(int unsigned gain, int lowest, int unsigned top);
        logic [CFG_DATA_W-1:0] w;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_register(CFG_GAIN, gain[GAIN_W-1:0]);
        w            = '0;
        w[LC_W-1:0]  = lowest[LC_W-1:0];
        write_register(CFG_LOWEST, w);
        w            = '0;
        w[TOP_W-1:0] = top[TOP_W-1:0];
        write_register(CFG_TOP, w);
    endtask

    // code whose resistance lands near target; random if out of reach
    function automatic logic [CODE_W-1:0] code_near(int unsigned target);
        longint unsigned c;
        if (gain_cfg == 0) begin
            return CODE_W'($urandom);
        end
        c = target;
        c = (c << 24) / (gain_cfg * 64'd100);
        if (c > CODE_MAX) begin
            return CODE_W'($urandom);
        end
        return c[CODE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Linear table, 5 ohm per degree from 100 ohm, with one flat step at
    // 300/301 and one falling step at 400/401. Every entry gets written
    // here, so no later search can touch an unwritten entry.
    task automatic test_table_load();
        int v;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            v = 10000 + 500 * i;
            if (i == 301) begin
                v = 10000 + 500 * 300;
            end else if (i == 401) begin
                v = 10000 + 500 * 400 - 100;
            end
            load_entry(i, v[RES_W-1:0]);
        end
    endtask

    // registers untouched since reset: gain 0 gives 0 centiohm
    task automatic test_reset_defaults();
        convert(0, 1'b0);
        convert(CODE_W'(CODE_MAX), 1'b1);
    endtask

    // exact resistance: code * 50 centiohm; entry k sits at code 200 + 10k
    task automatic test_interpolation();
        set_config(GAIN_HALF_OHM, -200, 510);
        convert(100, 1'b0);    // below entry 0
        convert(200, 1'b1);    // exact hit on entry 0, fault bit set
        convert(700, 1'b0);    // exact hit mid table
        convert(705, 1'b1);    // halfway between neighbours
        convert(701, 1'b0);    // just above an entry
    endtask

    task automatic test_irregular_steps();
        convert(3200, 1'b0);   // on the flat step
        convert(3205, 1'b1);   // just past the flat step
        convert(4199, 1'b0);   // around the falling step
        convert(4201, 1'b1);
        convert(20000, 1'b0);  // far above the last entry: fraction caps
        convert(CODE_W'(CODE_MAX), 1'b0);  // resistance saturates
    endtask

    // field extremes, search top and lowest degree at their limits
    task automatic test_clamp_and_saturation();
        load_entry(0, '0);
        load_entry(TABLE_DEPTH - 1, RES_MAX);
        set_config(GAIN_HALF_OHM, 255, 511);
        convert(CODE_W'(CODE_MAX), 1'b1);  // hits the top entry, index clamped
        set_config(GAIN_HALF_OHM, -256, 0);
        convert(700, 1'b0);                // search pinned at entry 0
        set_config(GAIN_HALF_OHM, -256, 1);
        convert(100, 1'b1);
        set_config(24'hFFFFFF, 0, 2);
        convert(1, 1'b0);
        convert(CODE_W'(CODE_MAX), 1'b1);
        set_config(0, -1, 510);
        convert(5, 1'b1);                  // 0 centiohm equals entry 0
    endtask

    task automatic load_random_table(table_shape_e shape);
        int v;
        int step;
        step = $urandom_range(300, 420);
        case (shape)
            SHAPE_PT1000:  v = $urandom_range(5000, 40000);
            SHAPE_PLATEAU: v = $urandom_range(0, 200000);
            default:       v = $urandom_range(500000, 900000);
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            load_entry(i, v[RES_W-1:0]);
            case (shape)
                SHAPE_PT1000:  v += step + int'($urandom_range(0, 10));
                SHAPE_PLATEAU: v += ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 2500));
                default:       v += int'($urandom_range(0, 900)) - 100;
            endcase
            if (v < 0) begin
                v = 0;
            end else if (v > int'(RES_MAX)) begin
                v = int'(RES_MAX);
            end
        end
    endtask

    // Eight phases of random requests. Each phase picks registers, sometimes
    // a fresh table shape, and its own idle pressure; most conversions aim
    // at a resistance close to some table entry.
    task automatic test_random_phases();
        int unsigned gain;
        int          lowest;
        int unsigned top;
        int          n_items;
        int          sel;
        int          v;
        int unsigned k;

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0:       gain = GAIN_PT1000 + $urandom_range(0, 100000);
                1:       gain = 24'hFFFFFF;
                2:       gain = $urandom;
                default: gain = $urandom_range(4000000, 8000000);
            endcase
            case (ph)
                0:       lowest = -256;
                1:       lowest = 255;
                default: lowest = $urandom_range(0, 511);
            endcase
            case (ph % 3)
                0:       top = 510;
                1:       top = 511;
                default: top = $urandom_range(2, 511);
            endcase
            set_config(gain, lowest, top);

            // phases 2 and 5 run with no idling at all
            case (ph)
                2, 5: begin
                    req_gap_pct   = 0;
                    res_stall_pct = 0;
                end
                4: begin
                    req_gap_pct   = 0;
                    res_stall_pct = 60;
                end
                default: begin
                    req_gap_pct   = 25;
                    res_stall_pct = 25;
                end
            endcase

            if (ph == 0) begin
                load_random_table(SHAPE_PT1000);
            end else if (ph == 3) begin
                load_random_table(SHAPE_PLATEAU);
            end else if (ph == 6) begin
                load_random_table(SHAPE_NOISY);
            end

            n_items = 0;
            while (n_items < 50) begin
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    // hold off until the block has drained
                    wait_drained();
                end else if (sel < 15) begin
                    k = $urandom_range(0, TABLE_DEPTH - 1);
                    if ($urandom_range(0, 3) == 0) begin
                        v = $urandom_range(0, int'(RES_MAX));
                    end else begin
                        v = int'(res_model[k]) + int'($urandom_range(0, 400)) - 200;
                        if (v < 0) begin
                            v = 0;
                        end else if (v > int'(RES_MAX)) begin
                            v = int'(RES_MAX);
                        end
                    end
                    load_entry(k, v[RES_W-1:0]);
                    n_items++;
                end else begin
                    if ($urandom_range(0, 9) < 7) begin
                        k = $urandom_range(0, TABLE_DEPTH - 1);
                        v = int'(res_model[k]) + int'($urandom_range(0, 600)) - 300;
                        if (v < 0) begin
                            v = 0;
                        end
                        convert(code_near(v), $urandom_range(0, 1));
                    end else begin
                        convert(CODE_W'($urandom), $urandom_range(0, 1));
                    end
                    n_items++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, then the tests in turn
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_reset_defaults();
        test_interpolation();
        test_irregular_steps();
        test_clamp_and_saturation();
        test_random_phases();

        // drain, then give stray results a chance to show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
